// File: design/vmiar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the exit-event audit ring.
// No dependencies; the controller, datapath, top level and checker import this package.
package vmiar_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W    = 1;
  localparam int REASON_W = 32;
  localparam int IDX_W    = 6;
  localparam int INV_W    = 4;
  localparam int ACT_W    = INV_W + 1;
  localparam int SEQ_W    = 48;
  localparam int TS_W     = 64;
  localparam int STORED_W = 7;

  // Default number of ring slots
  localparam int RING_DEPTH_DEF = 64;

  // Saturation point of the sequence counter
  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

  // Item opcodes
  localparam logic [CMD_W-1:0] CMD_EVENT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  // One ring record
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [TS_W-1:0]     ts;
    logic [REASON_W-1:0] reason;
    logic [INV_W-1:0]    inv;
    logic [ACT_W-1:0]    act;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic advance;    // an item was accepted: tick the timestamp
    logic log_event;  // exit event: count, write ring, load result
    logic rd_issue;   // read: start ring read, latch hit flag
    logic load_read;  // load the read result into the output register
  } ctrl_cmd_t;

endpackage

// File: design/vmiar_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmiar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/vmiar_ctrl.sv
`timescale 1ns / 1ps
// Controller: input handshake, read sequencing and output valid.
// Depends on vmiar_pkg.
module vmiar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                cmd,
  input  logic                out_stall,
  output logic                in_stall,
  output logic                out_valid,
  output vmiar_pkg::ctrl_cmd_t ctl
);
  import vmiar_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;
  logic   out_valid_next;

  // Take an item only when idle and the output register frees up
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Issue datapath commands
  always_comb begin
    ctl.advance   = accept;
    ctl.log_event = accept && (cmd == CMD_EVENT);
    ctl.rd_issue  = accept && (cmd == CMD_READ);
    ctl.load_read = (state == ST_READ) && out_free;
  end

  // Advance the state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.rd_issue) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (ctl.load_read) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drop valid once taken, raise it on a new result
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (ctl.log_event || ctl.load_read) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: design/vmiar_dp.sv
`timescale 1ns / 1ps
// Datapath: counters, ring pointers, record RAM and output register.
// Depends on vmiar_pkg and vmiar_ram.
module vmiar_dp #(
  parameter int RING_DEPTH = vmiar_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vmiar_pkg::ctrl_cmd_t            ctl,
  input  logic                            cfg_we,
  input  logic [vmiar_pkg::INV_W-1:0]     cfg_wdata,
  input  logic [vmiar_pkg::REASON_W-1:0]  reason_code,
  input  logic [vmiar_pkg::IDX_W-1:0]     read_index,
  output logic [vmiar_pkg::ACT_W-1:0]     actions,
  output logic [vmiar_pkg::SEQ_W-1:0]     event_total,
  output logic [vmiar_pkg::STORED_W-1:0]  stored_count,
  output logic                            record_valid,
  output logic [vmiar_pkg::SEQ_W-1:0]     record_sequence,
  output logic [vmiar_pkg::TS_W-1:0]      record_timestamp,
  output logic [vmiar_pkg::REASON_W-1:0]  record_reason,
  output logic [vmiar_pkg::INV_W-1:0]     record_invariants,
  output logic [vmiar_pkg::ACT_W-1:0]     record_actions
);
  import vmiar_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int KW = $clog2(RING_DEPTH + 1);
  localparam int SW = AW + IDX_W + 1;
  localparam int CW = KW + IDX_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [KW-1:0] DEPTH_K   = KW'(RING_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(RING_DEPTH);

  // State
  logic [INV_W-1:0] enables;
  logic [SEQ_W-1:0] event_count;
  logic [TS_W-1:0]  cycle_clock;
  logic [AW-1:0]    wptr;       // slot of the next unsaturated write
  logic             full;       // ring has wrapped at least once
  logic             rd_hit;

  // Event path
  logic             sat;
  logic [SEQ_W-1:0] count_next;
  logic [AW-1:0]    wptr_inc;
  logic [AW-1:0]    wptr_dec;
  logic [AW-1:0]    wslot;
  logic             full_next;
  logic [KW-1:0]    kept;
  logic [KW-1:0]    kept_next;
  logic [KW+STORED_W-1:0] kept_w;
  logic [KW+STORED_W-1:0] kept_next_w;
  logic [ACT_W-1:0] act_new;
  record_t          wrec;

  // Read path
  logic [SW-1:0]    idx_ext;
  logic [SW-1:0]    wptr_ext;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    sum_wrap;
  logic [AW-1:0]    rslot;
  logic             hit;
  logic [REC_W-1:0] rdata;
  record_t          rrec;

  // Saturating count and ring pointers
  assign sat        = (event_count == SEQ_MAX);
  assign count_next = sat ? event_count : event_count + 1'b1;
  assign wptr_inc   = (wptr == LAST_SLOT) ? '0 : wptr + 1'b1;
  assign wptr_dec   = (wptr == '0) ? LAST_SLOT : wptr - 1'b1;
  // A saturated event rewrites the slot of the maximum sequence
  assign wslot      = sat ? wptr_dec : wptr;
  assign full_next  = full || (!sat && (wptr == LAST_SLOT));

  // Kept record count, before and after this event
  assign kept        = full ? DEPTH_K : event_count[KW-1:0];
  assign kept_next   = full_next ? DEPTH_K : count_next[KW-1:0];
  assign kept_w      = {{STORED_W{1'b0}}, kept};
  assign kept_next_w = {{STORED_W{1'b0}}, kept_next};

  assign act_new = {enables, 1'b1};

  always_comb begin
    wrec.seq    = count_next;
    wrec.ts     = cycle_clock;
    wrec.reason = reason_code;
    wrec.inv    = enables;
    wrec.act    = act_new;
  end

  // Read slot: oldest slot plus index, wrapped once
  assign idx_ext  = {{(AW + 1){1'b0}}, read_index};
  assign wptr_ext = {{(IDX_W + 1){1'b0}}, wptr};
  assign sum      = wptr_ext + idx_ext;
  assign sum_wrap = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
  assign rslot    = full ? sum_wrap[AW-1:0] : idx_ext[AW-1:0];
  assign hit      = ({{KW{1'b0}}, read_index} < {{IDX_W{1'b0}}, kept});

  vmiar_ram #(
    .WIDTH(REC_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.log_event),
    .waddr(wslot),
    .wdata(wrec),
    .re   (ctl.rd_issue),
    .raddr(rslot),
    .rdata(rdata)
  );

  assign rrec = record_t'(rdata);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enables     <= '0;
      event_count <= '0;
      cycle_clock <= '0;
      wptr        <= '0;
      full        <= 1'b0;
    end else begin
      if (cfg_we) begin
        enables <= cfg_wdata;
      end
      if (ctl.advance) begin
        cycle_clock <= cycle_clock + 1'b1;
      end
      if (ctl.log_event) begin
        event_count <= count_next;
        full        <= full_next;
        if (!sat) begin
          wptr <= wptr_inc;
        end
      end
    end
  end

  // Hold the hit flag for the pending read
  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_hit <= hit;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (ctl.log_event) begin
      actions           <= act_new;
      event_total       <= count_next;
      stored_count      <= kept_next_w[STORED_W-1:0];
      record_valid      <= 1'b0;
      record_sequence   <= '0;
      record_timestamp  <= '0;
      record_reason     <= '0;
      record_invariants <= '0;
      record_actions    <= '0;
    end else if (ctl.load_read) begin
      actions           <= '0;
      event_total       <= event_count;
      stored_count      <= kept_w[STORED_W-1:0];
      record_valid      <= rd_hit;
      record_sequence   <= rd_hit ? rrec.seq    : '0;
      record_timestamp  <= rd_hit ? rrec.ts     : '0;
      record_reason     <= rd_hit ? rrec.reason : '0;
      record_invariants <= rd_hit ? rrec.inv    : '0;
      record_actions    <= rd_hit ? rrec.act    : '0;
    end
  end

endmodule

// File: design/vmexit_invariant_audit_ring_core.sv
`timescale 1ns / 1ps
// Top level of the exit-event audit ring: controller plus datapath.
// Depends on vmiar_pkg, vmiar_ctrl, vmiar_dp (and vmiar_ram below it).
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | cmd, reason_code, read_index
//  out     | out_valid / out_stall | actions, event_total, stored_count,
//          |                       | record_valid, record_* fields
//  cfg     | cfg_we                | cfg_wdata (invariant enables)
//
// An exit event's result is valid the cycle after accept, and back-to-back
// events run at one item per cycle while the output is not stalled.
// A read passes through the registered read port of the record RAM, then the output register.
// A stalled result holds the output register and stalls the input side.
// Synchronous reset clears counts, timestamp, enables and handshake state;
// ring contents are not cleared.
module vmexit_invariant_audit_ring_core #(
  parameter int RING_DEPTH = vmiar_pkg::RING_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [vmiar_pkg::REASON_W-1:0]  reason_code,
  input  logic [vmiar_pkg::IDX_W-1:0]     read_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vmiar_pkg::ACT_W-1:0]     actions,
  output logic [vmiar_pkg::SEQ_W-1:0]     event_total,
  output logic [vmiar_pkg::STORED_W-1:0]  stored_count,
  output logic                            record_valid,
  output logic [vmiar_pkg::SEQ_W-1:0]     record_sequence,
  output logic [vmiar_pkg::TS_W-1:0]      record_timestamp,
  output logic [vmiar_pkg::REASON_W-1:0]  record_reason,
  output logic [vmiar_pkg::INV_W-1:0]     record_invariants,
  output logic [vmiar_pkg::ACT_W-1:0]     record_actions,
  input  logic                            cfg_we,
  input  logic [vmiar_pkg::INV_W-1:0]     cfg_wdata
);
  import vmiar_pkg::*;

  ctrl_cmd_t ctl;

  vmiar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .out_stall(out_stall),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .ctl      (ctl)
  );

  vmiar_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .reason_code      (reason_code),
    .read_index       (read_index),
    .actions          (actions),
    .event_total      (event_total),
    .stored_count     (stored_count),
    .record_valid     (record_valid),
    .record_sequence  (record_sequence),
    .record_timestamp (record_timestamp),
    .record_reason    (record_reason),
    .record_invariants(record_invariants),
    .record_actions   (record_actions)
  );

endmodule

// File: design/vmiar_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the audit ring top level, and the bind that attaches them.
// Depends on vmiar_pkg and vmexit_invariant_audit_ring_core.
module vmiar_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            cmd,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [vmiar_pkg::ACT_W-1:0]     actions,
  input logic [vmiar_pkg::SEQ_W-1:0]     event_total,
  input logic                            record_valid,
  input logic [vmiar_pkg::SEQ_W-1:0]     record_sequence
);
  import vmiar_pkg::*;

  // A stalled result stays valid and keeps its count
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_total))
    else $error("stalled result changed");

  // An accepted event shows its result in the next cycle
  a_event_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_EVENT) |=> out_valid && actions[0])
    else $error("event result missing");

  // A kept record carries a nonzero sequence and no event actions
  a_read_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_valid |-> (actions == '0) && (record_sequence != '0)
      && (event_total != '0))
    else $error("bad read record");

  // Event results always have the observed bit and no record
  a_event_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (actions != '0) |-> actions[0] && !record_valid)
    else $error("bad action mask");

  // Reset drops the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind vmexit_invariant_audit_ring_core vmiar_checker u_vmiar_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .cmd            (cmd),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .actions        (actions),
  .event_total    (event_total),
  .record_valid   (record_valid),
  .record_sequence(record_sequence)
);
